[hw/rtl/on_demand_traffic_light_sequencer_core_macros.svh]
// Assertion macros for the on-demand traffic light sequencer core.
// Included by the top level; the including module must provide clk_i and rst_ni.
`ifndef ON_DEMAND_TRAFFIC_LIGHT_SEQUENCER_CORE_MACROS_SVH
`define ON_DEMAND_TRAFFIC_LIGHT_SEQUENCER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define ODTLS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ODTLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/odtls_pkg.sv]
// Shared types and constants for the on-demand traffic light sequencer.
// No dependencies; imported by every module of the block.
package odtls_pkg;

  // Widths of the configuration registers and port
  localparam int CFG_TIME_W  = 16;
  localparam int CFG_COUNT_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_CHUNK   = 3'd0,
    REG_CHUNK_COUNT  = 3'd1,
    REG_CAR_BLINK_ON = 3'd2,
    REG_CAR_BLINK_OFF = 3'd3,
    REG_SH_BLINK_ON  = 3'd4,
    REG_SH_BLINK_OFF = 3'd5,
    REG_WALK         = 3'd6,
    REG_BLINK_COUNT  = 3'd7
  } cfg_idx_e;

  // Reset values of the registers
  localparam logic [CFG_TIME_W-1:0]  RST_POLL_CHUNK    = 16'd68;
  localparam logic [CFG_COUNT_W-1:0] RST_CHUNK_COUNT   = 8'd50;
  localparam logic [CFG_TIME_W-1:0]  RST_CAR_BLINK_ON  = 16'd380;
  localparam logic [CFG_TIME_W-1:0]  RST_CAR_BLINK_OFF = 16'd180;
  localparam logic [CFG_TIME_W-1:0]  RST_SH_BLINK_ON   = 16'd390;
  localparam logic [CFG_TIME_W-1:0]  RST_SH_BLINK_OFF  = 16'd190;
  localparam logic [CFG_TIME_W-1:0]  RST_WALK          = 16'd5000;
  localparam logic [CFG_COUNT_W-1:0] RST_BLINK_COUNT   = 8'd5;

  typedef struct packed {
    logic [CFG_TIME_W-1:0]  poll_chunk;
    logic [CFG_COUNT_W-1:0] chunk_count;
    logic [CFG_TIME_W-1:0]  car_blink_on;
    logic [CFG_TIME_W-1:0]  car_blink_off;
    logic [CFG_TIME_W-1:0]  sh_blink_on;
    logic [CFG_TIME_W-1:0]  sh_blink_off;
    logic [CFG_TIME_W-1:0]  walk;
    logic [CFG_COUNT_W-1:0] blink_count;
  } cfg_t;

  // Car phase of the sequencer
  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2,
    PH_WALK   = 2'd3
  } phase_e;

  // Phase that a car-only yellow was entered from
  typedef enum logic [1:0] {
    FROM_GREEN = 2'd0,
    FROM_NONE  = 2'd1,
    FROM_RED   = 2'd2
  } origin_e;

  localparam int SEG_W = 3;

  // Segments of green and red
  localparam logic [SEG_W-1:0] SEG_WAIT = 3'd0;
  // Segments of yellow: car-only blink, then shared blink
  localparam logic [SEG_W-1:0] SEG_CAR_ON1 = 3'd0;
  localparam logic [SEG_W-1:0] SEG_CAR_OFF = 3'd1;
  localparam logic [SEG_W-1:0] SEG_CAR_ON2 = 3'd2;
  localparam logic [SEG_W-1:0] SEG_SH_ON1  = 3'd3;
  localparam logic [SEG_W-1:0] SEG_SH_OFF  = 3'd4;
  localparam logic [SEG_W-1:0] SEG_SH_ON2  = 3'd5;
  // Segments of the walk sequence: walk, then blink with walk green lit
  localparam logic [SEG_W-1:0] SEG_WALK   = 3'd0;
  localparam logic [SEG_W-1:0] SEG_WB_ON1 = 3'd1;
  localparam logic [SEG_W-1:0] SEG_WB_OFF = 3'd2;
  localparam logic [SEG_W-1:0] SEG_WB_ON2 = 3'd3;

  typedef struct packed {
    logic car_green;
    logic car_yellow;
    logic car_red;
    logic walk_green;
    logic walk_yellow;
    logic walk_red;
  } lamps_t;

endpackage

[hw/rtl/odtls_cfg.sv]
// Configuration register file of the traffic light sequencer.
// Depends on odtls_pkg for register indexes, reset values and cfg_t.
module odtls_cfg import odtls_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_POLL_CHUNK:    cfg_d.poll_chunk    = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_CHUNK_COUNT:   cfg_d.chunk_count   = cfg_wdata_i[CFG_COUNT_W-1:0];
        REG_CAR_BLINK_ON:  cfg_d.car_blink_on  = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_CAR_BLINK_OFF: cfg_d.car_blink_off = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_SH_BLINK_ON:   cfg_d.sh_blink_on   = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_SH_BLINK_OFF:  cfg_d.sh_blink_off  = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_WALK:          cfg_d.walk          = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_BLINK_COUNT:   cfg_d.blink_count   = cfg_wdata_i[CFG_COUNT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the registers, reset to their documented values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_chunk    <= RST_POLL_CHUNK;
      cfg_q.chunk_count   <= RST_CHUNK_COUNT;
      cfg_q.car_blink_on  <= RST_CAR_BLINK_ON;
      cfg_q.car_blink_off <= RST_CAR_BLINK_OFF;
      cfg_q.sh_blink_on   <= RST_SH_BLINK_ON;
      cfg_q.sh_blink_off  <= RST_SH_BLINK_OFF;
      cfg_q.walk          <= RST_WALK;
      cfg_q.blink_count   <= RST_BLINK_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/odtls_seq.sv]
// Phase sequencer: state registers, tick timing and lamp decode.
// Depends on odtls_pkg for phase and segment codes, cfg_t and lamps_t.
module odtls_seq import odtls_pkg::*; #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   step_i,
  input  logic   press_i,
  output lamps_t lamps_o
);

  localparam int LW = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam int CW = (COUNT_BITS > CFG_COUNT_W) ? COUNT_BITS : CFG_COUNT_W;

  phase_e                phase_q, phase_d;
  origin_e               from_q, from_d;
  logic [SEG_W-1:0]      seg_q, seg_d;
  logic                  req_q, req_d;
  logic [COUNT_BITS-1:0] rep_q, rep_d;
  logic [TIME_BITS-1:0]  tick_q, tick_d;

  logic                  req_now;
  logic [CFG_TIME_W-1:0] len_raw;
  logic [LW-1:0]         len_ext, len_max, len_clamp;
  logic [TIME_BITS-1:0]  len_eff, tick_inc;
  logic                  seg_done;
  logic [CFG_COUNT_W-1:0] cnt_raw;
  logic [CW-1:0]         cnt_ext, cnt_max, cnt_clamp;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic [COUNT_BITS:0]   rep_inc;
  logic                  more;

  // Latch a press at once, except during the walk sequence
  assign req_now = req_q | ((phase_q != PH_WALK) & press_i);

  // Select the length of the current segment
  always_comb begin
    case (phase_q)
      PH_GREEN, PH_RED: len_raw = cfg_i.poll_chunk;
      PH_YELLOW: begin
        if (seg_q == SEG_CAR_OFF)      len_raw = cfg_i.car_blink_off;
        else if (seg_q == SEG_SH_OFF)  len_raw = cfg_i.sh_blink_off;
        else if (seg_q <= SEG_CAR_ON2) len_raw = cfg_i.car_blink_on;
        else                           len_raw = cfg_i.sh_blink_on;
      end
      default: begin
        if (seg_q == SEG_WALK)        len_raw = cfg_i.walk;
        else if (seg_q == SEG_WB_OFF) len_raw = cfg_i.sh_blink_off;
        else                          len_raw = cfg_i.sh_blink_on;
      end
    endcase
  end

  // Clamp the length to the tick counter, zero acts as one
  assign len_ext   = LW'(len_raw);
  assign len_max   = LW'({TIME_BITS{1'b1}});
  assign len_clamp = (len_ext > len_max) ? len_max : len_ext;
  assign len_eff   = (len_clamp == '0) ? TIME_BITS'(1) : len_clamp[TIME_BITS-1:0];
  assign tick_inc  = tick_q + TIME_BITS'(1);
  assign seg_done  = (tick_inc >= len_eff) || (tick_inc == '0);

  // Clamp the repeat count in the same way and test for another repeat
  assign cnt_raw   = ((phase_q == PH_GREEN) || (phase_q == PH_RED)) ?
                     cfg_i.chunk_count : cfg_i.blink_count;
  assign cnt_ext   = CW'(cnt_raw);
  assign cnt_max   = CW'({COUNT_BITS{1'b1}});
  assign cnt_clamp = (cnt_ext > cnt_max) ? cnt_max : cnt_ext;
  assign cnt_eff   = (cnt_clamp == '0) ? COUNT_BITS'(1) : cnt_clamp[COUNT_BITS-1:0];
  assign rep_inc   = {1'b0, rep_q} + (COUNT_BITS+1)'(1);
  assign more      = rep_inc < {1'b0, cnt_eff};

  // Next state: advance the tick and close the segment when it runs out
  always_comb begin
    phase_d = phase_q;
    from_d  = from_q;
    seg_d   = seg_q;
    req_d   = req_q;
    rep_d   = rep_q;
    tick_d  = tick_q;
    if (step_i) begin
      req_d  = req_now;
      tick_d = tick_inc;
      if (seg_done) begin
        tick_d = '0;
        case (phase_q)
          PH_GREEN, PH_RED: begin
            if (seg_q != SEG_WAIT) begin
              phase_d = PH_GREEN;
              seg_d   = SEG_WAIT;
              rep_d   = '0;
              from_d  = FROM_NONE;
            end else if (!req_now && more) begin
              rep_d = rep_inc[COUNT_BITS-1:0];
            end else if (phase_q == PH_GREEN) begin
              from_d  = FROM_GREEN;
              phase_d = PH_YELLOW;
              seg_d   = req_now ? SEG_SH_ON1 : SEG_CAR_ON1;
              rep_d   = '0;
            end else if (req_now) begin
              phase_d = PH_WALK;
              seg_d   = SEG_WALK;
              rep_d   = '0;
            end else begin
              from_d  = FROM_RED;
              phase_d = PH_YELLOW;
              seg_d   = SEG_CAR_ON1;
              rep_d   = '0;
            end
          end
          PH_YELLOW: begin
            if (seg_q == SEG_CAR_ON1 || seg_q == SEG_CAR_OFF ||
                seg_q == SEG_SH_ON1 || seg_q == SEG_SH_OFF) begin
              seg_d = seg_q + SEG_W'(1);
            end else if (seg_q == SEG_CAR_ON2) begin
              if (req_now) begin
                from_d = FROM_NONE;
                seg_d  = SEG_SH_ON1;
                rep_d  = '0;
              end else if (more) begin
                seg_d = SEG_CAR_ON1;
                rep_d = rep_inc[COUNT_BITS-1:0];
              end else begin
                seg_d = SEG_WAIT;
                rep_d = '0;
                case (from_q)
                  FROM_GREEN: begin
                    from_d  = FROM_NONE;
                    phase_d = PH_RED;
                  end
                  FROM_RED: begin
                    from_d  = FROM_NONE;
                    phase_d = PH_GREEN;
                  end
                  default: begin
                    phase_d = PH_YELLOW;
                    seg_d   = SEG_CAR_ON1;
                  end
                endcase
              end
            end else if (seg_q == SEG_SH_ON2) begin
              if (more) begin
                seg_d = SEG_SH_ON1;
                rep_d = rep_inc[COUNT_BITS-1:0];
              end else begin
                phase_d = PH_WALK;
                seg_d   = SEG_WALK;
                rep_d   = '0;
              end
            end else begin
              phase_d = PH_GREEN;
              seg_d   = SEG_WAIT;
              rep_d   = '0;
              from_d  = FROM_NONE;
            end
          end
          default: begin
            if (seg_q == SEG_WALK || seg_q == SEG_WB_ON1 || seg_q == SEG_WB_OFF) begin
              seg_d = seg_q + SEG_W'(1);
            end else if (seg_q == SEG_WB_ON2 && more) begin
              seg_d = SEG_WB_ON1;
              rep_d = rep_inc[COUNT_BITS-1:0];
            end else begin
              req_d   = 1'b0;
              from_d  = FROM_NONE;
              phase_d = PH_GREEN;
              seg_d   = SEG_WAIT;
              rep_d   = '0;
            end
          end
        endcase
      end
    end
  end

  // Decode the lamps of the current segment
  always_comb begin
    lamps_o = '0;
    case (phase_q)
      PH_GREEN: lamps_o.car_green = (seg_q == SEG_WAIT);
      PH_RED:   lamps_o.car_red   = (seg_q == SEG_WAIT);
      PH_YELLOW: begin
        case (seg_q)
          SEG_CAR_ON1, SEG_CAR_ON2: lamps_o.car_yellow = 1'b1;
          SEG_SH_ON1, SEG_SH_ON2: begin
            lamps_o.car_yellow  = 1'b1;
            lamps_o.walk_yellow = 1'b1;
            lamps_o.walk_red    = 1'b1;
          end
          SEG_SH_OFF: lamps_o.walk_red = 1'b1;
          default:    lamps_o = '0;
        endcase
      end
      default: begin
        case (seg_q)
          SEG_WALK: begin
            lamps_o.car_red    = 1'b1;
            lamps_o.walk_green = 1'b1;
          end
          SEG_WB_ON1, SEG_WB_ON2: begin
            lamps_o.car_yellow  = 1'b1;
            lamps_o.walk_green  = 1'b1;
            lamps_o.walk_yellow = 1'b1;
          end
          SEG_WB_OFF: lamps_o.walk_green = 1'b1;
          default:    lamps_o = '0;
        endcase
      end
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_GREEN;
      from_q  <= FROM_NONE;
      seg_q   <= SEG_WAIT;
      req_q   <= 1'b0;
      rep_q   <= '0;
      tick_q  <= '0;
    end else begin
      phase_q <= phase_d;
      from_q  <= from_d;
      seg_q   <= seg_d;
      req_q   <= req_d;
      rep_q   <= rep_d;
      tick_q  <= tick_d;
    end
  end

endmodule

[hw/rtl/on_demand_traffic_light_sequencer_core.sv]
// On-demand traffic light sequencer: one timer tick in, one set of six lamps out.
// Depends on odtls_pkg, odtls_cfg, odtls_seq and the assertion macro header.
//
// Each input transaction is one timer tick carrying a crosswalk-button pulse; each
// output transaction gives the six lamp states during that tick. The block takes
// one tick per clock cycle while the output is drained; the tick is
// held in an input register, and in the cycle it moves on the sequencer updates
// its phase, segment, repeat and tick counters in one pass while the lamp decode
// is captured in the output register. A new tick is accepted while a result waits
// at the output, as long as the input register is free or moving on. The
// configuration registers may be written whenever no tick is in flight; they take
// effect from the next tick.
`include "on_demand_traffic_light_sequencer_core_macros.svh"

module on_demand_traffic_light_sequencer_core import odtls_pkg::*; #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  button_press_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  car_green_o,
  output logic                  car_yellow_o,
  output logic                  car_red_o,
  output logic                  walk_green_o,
  output logic                  walk_yellow_o,
  output logic                  walk_red_o
);

  cfg_t   cfg;
  lamps_t lamps_now;
  lamps_t lamps_q;
  logic   in_valid_q, in_valid_d;
  logic   press_q;
  logic   out_valid_q, out_valid_d;
  logic   advance;

  odtls_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  odtls_seq #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (advance),
    .press_i (press_q),
    .lamps_o (lamps_now)
  );

  // Move the held tick on when the output register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_ready_o ? in_valid_i : in_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the tick and the lamp result
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      press_q <= button_press_i;
    end
    if (advance) begin
      lamps_q <= lamps_now;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign car_green_o   = lamps_q.car_green;
  assign car_yellow_o  = lamps_q.car_yellow;
  assign car_red_o     = lamps_q.car_red;
  assign walk_green_o  = lamps_q.walk_green;
  assign walk_yellow_o = lamps_q.walk_yellow;
  assign walk_red_o    = lamps_q.walk_red;

  // At most one car lamp is lit in any result
  `ODTLS_ASSERT_SAME(a_car_lamps_onehot, out_valid_o, $onehot0({car_green_o, car_yellow_o, car_red_o}), "more than one car lamp lit")
  // Pedestrian lamps are dark while cars have green
  `ODTLS_ASSERT_SAME(a_green_walk_dark, out_valid_o && car_green_o, !(walk_green_o || walk_yellow_o || walk_red_o), "pedestrian lamp lit with car green")
  // Input stalls only behind a held tick and a stalled result
  `ODTLS_ASSERT_SAME(a_stall_cause, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled without cause")
  // A drained result with nothing behind it leaves the output empty
  `ODTLS_ASSERT_NEXT(a_drain_empty, out_valid_o && out_ready_i && !in_valid_q, !out_valid_o, "result appeared without a tick")

endmodule
